/* hw/rtl/tlm_pkg.sv */
// shared constants and register codes for the two-lane merge scheduler
package tlm_pkg;
	localparam int unsigned MAX_PER_LANE_DEF = 32;
	localparam int unsigned HW_W = 20;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned ID_W = 16;
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_HW_SAME = 1'b0;
	localparam logic REG_HW_CROSS = 1'b1;
	localparam logic [HW_W-1:0] HW_SAME_RST = 20'd131072;
	localparam logic [HW_W-1:0] HW_CROSS_RST = 20'd196608;
	localparam logic [TIME_W-1:0] SAT_MAX = '1;
endpackage

/* hw/rtl/tlm_cand.sv */
// one predecessor candidate: pass time and accumulated delay
module tlm_cand import tlm_pkg::*; (
	input  logic [TIME_W-1:0] prev_time,
	input  logic [TIME_W-1:0] prev_delay,
	input  logic [HW_W-1:0]   headway,
	input  logic [TIME_W-1:0] tmin,
	output logic [TIME_W-1:0] t,
	output logic [TIME_W-1:0] d
);
	logic [TIME_W:0] ready_sum;
	logic [TIME_W-1:0] ready;
	logic [TIME_W:0] delay_sum;

	always_comb begin
		ready_sum = {1'b0, prev_time} + {{(TIME_W+1-HW_W){1'b0}}, headway};
		ready = ready_sum[TIME_W] ? SAT_MAX : ready_sum[TIME_W-1:0];
		t = (ready > tmin) ? ready : tmin;
		delay_sum = {1'b0, prev_delay} + {1'b0, t - tmin};
		d = delay_sum[TIME_W] ? SAT_MAX : delay_sum[TIME_W-1:0];
	end
endmodule

/* hw/rtl/two_lane_merge_order_dp_core.sv */
// top level: vehicle load, cell table sweep, traceback and merged order output
//
//  channel  direction  handshake             payload
//  item     in         item_valid/item_stall lane, vehicle_id, min_time, last
//  result   out        res_valid/res_stall   out_vehicle_id, out_lane, pass_time,
//                                            total_delay, dropped, last_out
//  config   in         apb write/read        headway_same_lane, headway_cross_lane
//
// a load beat is taken only while idle; the beat marked last starts the schedule
// the sweep runs read, candidate and write states per cell on the single cell
// memory write port, only the read state per skipped cell; traceback reads and
// steps per vehicle; result beats hold under stall; no clearing pass after reset
module two_lane_merge_order_dp_core import tlm_pkg::*; #(
	parameter int unsigned MAX_PER_LANE = MAX_PER_LANE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 lane,
	input  logic [ID_W-1:0]      vehicle_id,
	input  logic [TIME_W-1:0]    min_time,
	input  logic                 last,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [ID_W-1:0]      out_vehicle_id,
	output logic                 out_lane,
	output logic [TIME_W-1:0]    pass_time,
	output logic [TIME_W-1:0]    total_delay,
	output logic                 dropped,
	output logic                 last_out
);
	localparam int unsigned SIDE = MAX_PER_LANE + 1;
	localparam int unsigned NCELLS = SIDE * SIDE * 2;
	localparam int unsigned FW = $clog2(MAX_PER_LANE + 1);
	localparam int unsigned SW = $clog2(2 * MAX_PER_LANE);
	localparam int unsigned CW = $clog2(NCELLS);
	localparam int unsigned KW = $clog2(2 * MAX_PER_LANE + 1);
	localparam int unsigned PW = 2 * MAX_PER_LANE;
	localparam int unsigned CDW = 2 * TIME_W + 1;
	localparam int unsigned SDW = TIME_W + ID_W;
	localparam logic [FW-1:0] MAX_F = FW'(MAX_PER_LANE);

	typedef enum logic [3:0] {
		S_IDLE, S_DP_RD, S_DP_C1, S_DP_C2, S_FIN_RD, S_FIN_CMP,
		S_TB_RD, S_TB_STEP, S_EM_RD, S_EM_LOAD, S_EM_OUT
	} state_t;

	function automatic logic [CW-1:0] cell_idx(logic [FW-1:0] m, logic [FW-1:0] n, logic r);
		logic [CW-1:0] row;
		row = CW'(m) * CW'(SIDE) + CW'(n);
		return {row[CW-2:0], r};
	endfunction

	state_t state_q;
	logic [HW_W-1:0] hw_same_q, hw_cross_q;
	logic [FW-1:0] fill0_q, fill1_q;
	logic ovf_q;
	logic [FW-1:0] m_q, n_q;
	logic r_q;
	logic [KW-1:0] cnt_q;
	logic [PW-1:0] path_q;

	logic [CDW-1:0] cell_mem [NCELLS];
	logic [SDW-1:0] store_mem [2*MAX_PER_LANE];
	logic [CDW-1:0] rd_a_q, rd_b_q;
	logic [SDW-1:0] st_rd_q;

	logic [CW-1:0] addr_a, addr_b;
	logic [SW-1:0] st_addr;
	logic cell_we;
	logic [CDW-1:0] cell_wd;
	logic st_we;
	logic [SW-1:0] st_waddr;

	logic [TIME_W-1:0] t0_s1, d0_s1, t1_s1, d1_s1, tmin_s1;
	logic v0_s1, v1_s1;
	logic [TIME_W-1:0] c0_t, c0_d, c1_t, c1_d;

	logic cell_ok, adv_done;
	logic [FW-1:0] pm, pn, mn, nn;
	logic em_r;
	logic accept;
	logic [FW-1:0] fill_sel;

	assign pready = 1'b1;
	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && !item_stall;
	assign fill_sel = lane ? fill1_q : fill0_q;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_HW_CROSS) begin
			prdata = {{(32-HW_W){1'b0}}, hw_cross_q};
		end else begin
			prdata = {{(32-HW_W){1'b0}}, hw_same_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_same_q <= HW_SAME_RST;
			hw_cross_q <= HW_CROSS_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_HW_SAME) begin
				hw_same_q <= pwdata[HW_W-1:0];
			end else begin
				hw_cross_q <= pwdata[HW_W-1:0];
			end
		end
	end

	always_comb begin
		cell_ok = r_q ? (n_q != '0) : (m_q != '0);
		adv_done = r_q && (n_q == fill1_q) && (m_q == fill0_q);
		pm = r_q ? m_q : m_q - 1'b1;
		pn = r_q ? n_q - 1'b1 : n_q;
		em_r = path_q[0];
		mn = m_q + FW'(!em_r);
		nn = n_q + FW'(em_r);
		st_we = accept && (fill_sel < MAX_F);
		st_waddr = SW'(lane ? MAX_PER_LANE : 0) + SW'(fill_sel);
		addr_a = cell_idx(pm, pn, 1'b0);
		addr_b = cell_idx(pm, pn, 1'b1);
		st_addr = r_q ? SW'(MAX_PER_LANE) + SW'(n_q) - 1'b1 : SW'(m_q) - 1'b1;
		unique case (state_q)
			S_FIN_RD: begin
				addr_a = cell_idx(fill0_q, fill1_q, 1'b0);
				addr_b = cell_idx(fill0_q, fill1_q, 1'b1);
			end
			S_TB_RD: addr_a = cell_idx(m_q, n_q, r_q);
			S_EM_RD: begin
				addr_a = cell_idx(mn, nn, em_r);
				st_addr = em_r ? SW'(MAX_PER_LANE) + SW'(nn) - 1'b1 : SW'(mn) - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= {vehicle_id, min_time};
		end
		st_rd_q <= store_mem[st_addr];
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_idx(m_q, n_q, r_q)] <= cell_wd;
		end
		rd_a_q <= cell_mem[addr_a];
		rd_b_q <= cell_mem[addr_b];
	end

	tlm_cand u_cand0 (
		.prev_time (rd_a_q[CDW-1:TIME_W+1]),
		.prev_delay(rd_a_q[TIME_W:1]),
		.headway   (r_q ? hw_cross_q : hw_same_q),
		.tmin      (st_rd_q[TIME_W-1:0]),
		.t         (c0_t),
		.d         (c0_d)
	);

	tlm_cand u_cand1 (
		.prev_time (rd_b_q[CDW-1:TIME_W+1]),
		.prev_delay(rd_b_q[TIME_W:1]),
		.headway   (r_q ? hw_same_q : hw_cross_q),
		.tmin      (st_rd_q[TIME_W-1:0]),
		.t         (c1_t),
		.d         (c1_d)
	);

	logic [TIME_W:0] cost0, cost1, fa, fb;
	logic sel1;
	always_comb begin
		cost0 = {1'b0, t0_s1} + {1'b0, d0_s1};
		cost1 = {1'b0, t1_s1} + {1'b0, d1_s1};
		sel1 = v1_s1 && (!v0_s1 || (cost1 < cost0));
		cell_we = (state_q == S_DP_C2);
		if (!v0_s1 && !v1_s1) begin
			cell_wd = {tmin_s1, {TIME_W{1'b0}}, 1'b0};
		end else if (sel1) begin
			cell_wd = {t1_s1, d1_s1, 1'b1};
		end else begin
			cell_wd = {t0_s1, d0_s1, 1'b0};
		end
		fa = {1'b0, rd_a_q[CDW-1:TIME_W+1]} + {1'b0, rd_a_q[TIME_W:1]};
		fb = {1'b0, rd_b_q[CDW-1:TIME_W+1]} + {1'b0, rd_b_q[TIME_W:1]};
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DP_C1) begin
			t0_s1 <= c0_t;
			d0_s1 <= c0_d;
			t1_s1 <= c1_t;
			d1_s1 <= c1_d;
			tmin_s1 <= st_rd_q[TIME_W-1:0];
			v0_s1 <= (pm != '0);
			v1_s1 <= (pn != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill0_q <= '0;
			fill1_q <= '0;
			ovf_q <= 1'b0;
			m_q <= '0;
			n_q <= '0;
			r_q <= 1'b0;
			cnt_q <= '0;
			path_q <= '0;
			res_valid <= 1'b0;
			out_vehicle_id <= '0;
			out_lane <= 1'b0;
			pass_time <= '0;
			total_delay <= '0;
			dropped <= 1'b0;
			last_out <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (fill_sel < MAX_F) begin
							if (lane) fill1_q <= fill1_q + 1'b1;
							else fill0_q <= fill0_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							m_q <= '0;
							n_q <= '0;
							r_q <= 1'b0;
							state_q <= S_DP_RD;
						end
					end
				end
				S_DP_RD: begin
					if (cell_ok) begin
						state_q <= S_DP_C1;
					end else if (adv_done) begin
						state_q <= S_FIN_RD;
					end else if (!r_q) begin
						r_q <= 1'b1;
					end else begin
						r_q <= 1'b0;
						if (n_q == fill1_q) begin
							n_q <= '0;
							m_q <= m_q + 1'b1;
						end else begin
							n_q <= n_q + 1'b1;
						end
					end
				end
				S_DP_C1: state_q <= S_DP_C2;
				S_DP_C2: begin
					if (adv_done) begin
						state_q <= S_FIN_RD;
					end else begin
						state_q <= S_DP_RD;
						if (!r_q) begin
							r_q <= 1'b1;
						end else begin
							r_q <= 1'b0;
							if (n_q == fill1_q) begin
								n_q <= '0;
								m_q <= m_q + 1'b1;
							end else begin
								n_q <= n_q + 1'b1;
							end
						end
					end
				end
				S_FIN_RD: state_q <= S_FIN_CMP;
				S_FIN_CMP: begin
					m_q <= fill0_q;
					n_q <= fill1_q;
					cnt_q <= KW'(fill0_q) + KW'(fill1_q);
					if (fill0_q == '0) r_q <= 1'b1;
					else if (fill1_q == '0) r_q <= 1'b0;
					else r_q <= (fb < fa);
					state_q <= S_TB_RD;
				end
				S_TB_RD: state_q <= S_TB_STEP;
				S_TB_STEP: begin
					path_q <= {path_q[PW-2:0], r_q};
					if (r_q) n_q <= n_q - 1'b1;
					else m_q <= m_q - 1'b1;
					r_q <= rd_a_q[0];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == KW'(1)) begin
						cnt_q <= KW'(fill0_q) + KW'(fill1_q);
						state_q <= S_EM_RD;
					end else begin
						state_q <= S_TB_RD;
					end
				end
				S_EM_RD: begin
					m_q <= mn;
					n_q <= nn;
					r_q <= em_r;
					state_q <= S_EM_LOAD;
				end
				S_EM_LOAD: begin
					out_vehicle_id <= st_rd_q[SDW-1:TIME_W];
					out_lane <= r_q;
					pass_time <= rd_a_q[CDW-1:TIME_W+1];
					total_delay <= rd_a_q[TIME_W:1];
					dropped <= ovf_q;
					last_out <= (cnt_q == KW'(1));
					res_valid <= 1'b1;
					state_q <= S_EM_OUT;
				end
				S_EM_OUT: begin
					if (!res_stall) begin
						res_valid <= 1'b0;
						path_q <= {1'b0, path_q[PW-1:1]};
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == KW'(1)) begin
							fill0_q <= '0;
							fill1_q <= '0;
							ovf_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* test/testbench.sv */
// self-checking testbench for the two-lane merge scheduler: random vehicle sets against a predictor
module testbench;
	import tlm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP = MAX_PER_LANE_DEF;
	localparam int unsigned SIDE = CAP + 1;
	localparam logic [TIME_W-1:0] SAT = SAT_MAX;

	typedef struct packed {
		logic              lane;
		logic [ID_W-1:0]   vid;
		logic [TIME_W-1:0] tmin;
		logic              last;
	} vehicle_t;

	typedef struct packed {
		logic [ID_W-1:0]   vid;
		logic              lane;
		logic [TIME_W-1:0] pass;
		logic [TIME_W-1:0] delay;
		logic              dropped;
		logic              last;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic lane = 1'b0;
	logic [ID_W-1:0] vehicle_id = '0;
	logic [TIME_W-1:0] min_time = '0;
	logic last = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [ID_W-1:0] out_vehicle_id;
	logic out_lane;
	logic [TIME_W-1:0] pass_time;
	logic [TIME_W-1:0] total_delay;
	logic dropped;
	logic last_out;
	logic in_fire = 1'b0;

	two_lane_merge_order_dp_core uut (.*);

	vehicle_t pending_vehicles[$];
	slot_t merged_order[$];
	int unsigned send_idle_pct = 0, stall_pct = 0;
	int unsigned errors = 0, beats_in = 0, beats_out = 0, sets_done = 0;

	// predictor state
	logic [HW_W-1:0] hw_same = HW_SAME_RST, hw_cross = HW_CROSS_RST;
	logic [TIME_W-1:0] tmin_store[2][CAP];
	logic [ID_W-1:0] id_store[2][CAP];
	int unsigned fill[2];
	logic overflow;
	logic [TIME_W-1:0] ct[SIDE][SIDE][2];
	logic [TIME_W-1:0] cd[SIDE][SIDE][2];
	logic cp[SIDE][SIDE][2];

	initial forever #5 clk = ~clk;

	function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? SAT : s[TIME_W-1:0];
	endfunction

	task automatic fill_cell(int m, int n, int r);
		int pm, pn;
		logic [TIME_W-1:0] tm, rdy, t, d;
		logic [TIME_W:0] cost, best;
		bit have;
		pm = r ? m : m - 1;
		pn = r ? n - 1 : n;
		tm = r ? tmin_store[1][n-1] : tmin_store[0][m-1];
		have = 0;
		best = '0;
		if (pm == 0 && pn == 0) begin
			ct[m][n][r] = tm;
			cd[m][n][r] = '0;
			cp[m][n][r] = 1'b0;
			return;
		end
		for (int pr = 0; pr < 2; pr++) begin
			if (pr == 0 && pm == 0) continue;
			if (pr == 1 && pn == 0) continue;
			rdy = sat_sum(ct[pm][pn][pr], (pr == r) ? TIME_W'(hw_same) : TIME_W'(hw_cross));
			t = (rdy > tm) ? rdy : tm;
			d = sat_sum(cd[pm][pn][pr], t - tm);
			cost = {1'b0, t} + {1'b0, d};
			if (!have || cost < best) begin
				have = 1;
				best = cost;
				ct[m][n][r] = t;
				cd[m][n][r] = d;
				cp[m][n][r] = pr[0];
			end
		end
	endtask

	task automatic predict_merge(vehicle_t v);
		int mm, nn, r, m, n, total;
		logic [TIME_W:0] ca, cb;
		slot_t order[$];
		slot_t s;
		if (fill[v.lane] < CAP) begin
			tmin_store[v.lane][fill[v.lane]] = v.tmin;
			id_store[v.lane][fill[v.lane]] = v.vid;
			fill[v.lane]++;
		end else
			overflow = 1'b1;
		if (!v.last) return;
		mm = fill[0];
		nn = fill[1];
		total = mm + nn;
		for (m = 0; m <= mm; m++)
			for (n = 0; n <= nn; n++) begin
				if (m >= 1) fill_cell(m, n, 0);
				if (n >= 1) fill_cell(m, n, 1);
			end
		if (mm == 0) r = 1;
		else if (nn == 0) r = 0;
		else begin
			ca = {1'b0, ct[mm][nn][0]} + {1'b0, cd[mm][nn][0]};
			cb = {1'b0, ct[mm][nn][1]} + {1'b0, cd[mm][nn][1]};
			r = (cb < ca) ? 1 : 0;
		end
		m = mm;
		n = nn;
		for (int k = total; k > 0; k--) begin
			s.vid = r ? id_store[1][n-1] : id_store[0][m-1];
			s.lane = r[0];
			s.pass = ct[m][n][r];
			s.delay = cd[m][n][r];
			s.dropped = overflow;
			s.last = (k == total);
			order = {s, order};
			if (r) begin
				r = cp[m][n][1];
				n--;
			end else begin
				r = cp[m][n][0];
				m--;
			end
		end
		merged_order = {merged_order, order};
		fill[0] = 0;
		fill[1] = 0;
		overflow = 1'b0;
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || in_fire) begin
				if (pending_vehicles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					vehicle_t v;
					v = pending_vehicles.pop_front();
					lane <= v.lane;
					vehicle_id <= v.vid;
					min_time <= v.tmin;
					last <= v.last;
					item_valid <= 1'b1;
				end else
					item_valid <= 1'b0;
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		in_fire <= arst_n && item_valid && !item_stall;
		if (arst_n && item_valid && !item_stall) begin
			predict_merge({lane, vehicle_id, min_time, last});
			beats_in++;
		end
		if (arst_n && res_valid && !res_stall) begin
			beats_out++;
			if (merged_order.size() == 0) begin
				$error("unexpected result beat id=%0h", out_vehicle_id);
				errors++;
			end else begin
				slot_t e;
				e = merged_order.pop_front();
				if (out_vehicle_id !== e.vid) begin
					$error("out_vehicle_id exp %0h got %0h", e.vid, out_vehicle_id);
					errors++;
				end
				if (out_lane !== e.lane) begin
					$error("out_lane exp %0h got %0h", e.lane, out_lane);
					errors++;
				end
				if (pass_time !== e.pass) begin
					$error("pass_time exp %0h got %0h", e.pass, pass_time);
					errors++;
				end
				if (total_delay !== e.delay) begin
					$error("total_delay exp %0h got %0h", e.delay, total_delay);
					errors++;
				end
				if (dropped !== e.dropped) begin
					$error("dropped exp %0h got %0h", e.dropped, dropped);
					errors++;
				end
				if (last_out !== e.last) begin
					$error("last_out exp %0h got %0h", e.last, last_out);
					errors++;
				end
				if (e.last) sets_done++;
			end
		end
	end

	task automatic reg_write(logic idx, logic [HW_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= {12'($urandom_range(4095)), val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_HW_SAME) hw_same = val;
		else hw_cross = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain;
		while (pending_vehicles.size() > 0 || item_valid || merged_order.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] rand_time(int unsigned base);
		case ($urandom_range(9))
			0: return SAT - $urandom_range(200000);
			1: return $urandom;
			default: return base + $urandom_range(400000);
		endcase
	endfunction

	task automatic queue_set(int unsigned n0, int unsigned n1, bit ordered);
		vehicle_t v;
		int unsigned k, total, t0, t1;
		total = n0 + n1;
		t0 = $urandom_range(1000000);
		t1 = t0 + $urandom_range(200000);
		k = 0;
		while (k < total) begin
			v.lane = (n0 == 0) ? 1'b1 : (n1 == 0) ? 1'b0 : 1'($urandom_range(1));
			if (v.lane) n1--; else n0--;
			v.vid = 16'($urandom);
			if (ordered) begin
				if (v.lane) begin
					t1 += $urandom_range(250000);
					v.tmin = t1;
				end else begin
					t0 += $urandom_range(250000);
					v.tmin = t0;
				end
			end else
				v.tmin = rand_time(t0);
			k++;
			v.last = (k == total);
			pending_vehicles = {pending_vehicles, v};
		end
	endtask

	initial begin
		int unsigned n0, n1;
		vehicle_t v;
		fill = '{0, 0};
		overflow = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: single vehicles, field extremes, both lanes
		v = '{lane: 1'b0, vid: 16'h0000, tmin: '0, last: 1'b1};
		pending_vehicles = {pending_vehicles, v};
		v = '{lane: 1'b1, vid: 16'hFFFF, tmin: SAT, last: 1'b1};
		pending_vehicles = {pending_vehicles, v};
		v = '{lane: 1'b0, vid: 16'hA5A5, tmin: SAT, last: 1'b0};
		pending_vehicles = {pending_vehicles, v};
		v = '{lane: 1'b1, vid: 16'h5A5A, tmin: SAT - 1, last: 1'b1};
		pending_vehicles = {pending_vehicles, v};
		// equal times on both lanes give cost ties
		for (int i = 0; i < 4; i++) begin
			v = '{lane: 1'(i), vid: 16'(i + 16), tmin: 32'h10000, last: (i == 3)};
			pending_vehicles = {pending_vehicles, v};
		end
		queue_set(3, 4, 1);
		drain();

		// zero headways, then maxima
		reg_write(REG_HW_SAME, '0);
		reg_write(REG_HW_CROSS, '0);
		queue_set(4, 3, 1);
		queue_set(2, 2, 0);
		drain();
		reg_write(REG_HW_SAME, 20'hFFFFF);
		reg_write(REG_HW_CROSS, 20'hFFFFF);
		queue_set(3, 3, 0);
		drain();

		// full lanes plus overflow in one set, both lanes
		reg_write(REG_HW_SAME, HW_SAME_RST);
		reg_write(REG_HW_CROSS, HW_CROSS_RST);
		queue_set(CAP + 2, CAP + 1, 1);
		drain();

		// random phases over idling modes and headway settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 80; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 80; end
				default: begin send_idle_pct = 11; stall_pct = 11; end
			endcase
			reg_write(REG_HW_SAME, HW_W'($urandom_range(655359)));
			reg_write(REG_HW_CROSS, HW_W'($urandom_range(655359)));
			for (int s = 0; s < 6; s++) begin
				n0 = $urandom_range(6);
				n1 = $urandom_range(6);
				if (n0 + n1 == 0) n0 = 1;
				queue_set(n0, n1, $urandom_range(4) != 0);
			end
			if (ph == 5) queue_set(CAP, CAP, 1);
			drain();
		end

		$display("vehicles loaded: %0d, merged beats checked: %0d, sets: %0d",
			beats_in, beats_out, sets_done);
		$display("covered field extremes, ties, overflow, headway extremes and stall modes");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
